// ===== sv/lpbd_pkg.sv =====
// ---------------------------------------------------------------------------
// LED pattern and button debounce package
// Shared types and constants for the LED pattern generator and the button
// debouncer: mode and phase encodings, operation codes and register indexes.
// ---------------------------------------------------------------------------
package lpbd_pkg;

  // Operation carried by an input word.
  typedef enum logic {
    OP_STEP = 1'b0,
    OP_SET  = 1'b1
  } op_t;

  // LED drive modes.
  typedef enum logic [1:0] {
    MODE_DARK   = 2'd0,
    MODE_LIT    = 2'd1,
    MODE_BLINK  = 2'd2,
    MODE_TRIPLE = 2'd3
  } led_mode_t;

  // Button machine phases.
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_PRESSED  = 2'd2
  } button_phase_t;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int TIME_W     = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_OFF = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_ON  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIPLE    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 4'd3;

  // Reset values of the configuration registers, in milliseconds.
  localparam logic [CFG_DATA_W-1:0] RST_BLINK_OFF = 16'd900;
  localparam logic [CFG_DATA_W-1:0] RST_BLINK_ON  = 16'd100;
  localparam logic [CFG_DATA_W-1:0] RST_TRIPLE    = 16'd200;
  localparam logic [CFG_DATA_W-1:0] RST_DEBOUNCE  = 16'd50;

  // Number of blinks in three-blink mode.
  localparam logic [1:0] TRIPLE_COUNT = 2'd3;

endpackage

// ===== sv/lpbd_ifs.sv =====
// ---------------------------------------------------------------------------
// LED pattern and button debounce channel interfaces
// Valid/ready channels for input words, result words and register writes.
// ---------------------------------------------------------------------------

// Input word channel.
interface lpbd_in_if;
  import lpbd_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [TIME_W-1:0] now_ms;
  logic              button_level;
  logic [1:0]        new_mode;

  modport source (output valid, op, now_ms, button_level, new_mode, input ready);
  modport sink   (input valid, op, now_ms, button_level, new_mode, output ready);
endinterface

// Result word channel.
interface lpbd_out_if;
  logic       valid;
  logic       ready;
  logic       led_level;
  logic       press_event;
  logic [1:0] led_mode_now;
  logic [1:0] button_phase_now;

  modport source (output valid, led_level, press_event, led_mode_now, button_phase_now,
                  input ready);
  modport sink   (input valid, led_level, press_event, led_mode_now, button_phase_now,
                  output ready);
endinterface

// Register write channel.
interface lpbd_cfg_if;
  import lpbd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/led_pattern_and_button_debounce.sv =====
// ---------------------------------------------------------------------------
// LED pattern generator with button debouncer
// Drives one LED in dark, lit, blink or three-blink mode and debounces an
// active-low button, one result word for every input word.
// ---------------------------------------------------------------------------
// Usage:
// Input words arrive on in_ch. A step word carries the current millisecond
// time and the raw button level; a set word replaces the LED mode. Every
// input word yields exactly one result word on out_ch with the LED level,
// a press flag, the LED mode and the button phase after that word.
// Registers are written on cfg_ch (index 0 blink off time, 1 blink on time,
// 2 three-blink phase time, 3 debounce time); cfg_ch is always ready. The
// user must write it only while no word is in flight; the block does not
// enforce this. An accepted word sits in the input register while the mode
// logic works, and the result register loads when the word moves on to it.
// Throughput is one word per clock while out_ch is ready; the 32-bit
// subtract and compares of each timer set the cycle.
// Reset (rst_n low, synchronous) empties both registers, selects blink
// mode, idles the button machine and loads the default times.
// When the receiver stalls, the held result stays put and at most one more
// word is taken into the input register before in_ch.ready falls.
// ---------------------------------------------------------------------------
module led_pattern_and_button_debounce (
  input  logic clk,
  input  logic rst_n,
  lpbd_in_if.sink    in_ch,
  lpbd_out_if.source out_ch,
  lpbd_cfg_if.sink   cfg_ch
);
  import lpbd_pkg::*;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] blink_off_r, blink_on_r, triple_time_r, debounce_r;

  // Input register.
  logic              in_vld_r;
  op_t               in_op_r;
  logic [TIME_W-1:0] in_now_r;
  logic              in_level_r;
  logic [1:0]        in_mode_r;

  // Block state.
  led_mode_t         led_mode_r, led_mode_nxt;
  button_phase_t     phase_r, phase_nxt;
  logic [TIME_W-1:0] led_mark_r, led_mark_nxt;
  logic [TIME_W-1:0] button_mark_r, button_mark_nxt;
  logic              blink_phase_r, blink_phase_nxt;
  logic              triple_phase_r, triple_phase_nxt;
  logic [1:0]        blink_count_r, blink_count_nxt;
  logic              led_pin_r, led_pin_nxt;
  logic              event_nxt;

  // Result register.
  logic          out_vld_r;
  logic          out_led_r, out_event_r;
  led_mode_t     out_mode_r;
  button_phase_t out_phase_r;

  logic              advance;
  logic [TIME_W-1:0] led_elapsed, button_elapsed;
  logic [1:0]        count_inc;

  // Handshake: the word in the input register moves on when the result slot frees.
  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;
  assign cfg_ch.ready = 1'b1;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_off_r   <= RST_BLINK_OFF;
      blink_on_r    <= RST_BLINK_ON;
      triple_time_r <= RST_TRIPLE;
      debounce_r    <= RST_DEBOUNCE;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_BLINK_OFF: blink_off_r   <= cfg_ch.data;
        CFG_BLINK_ON:  blink_on_r    <= cfg_ch.data;
        CFG_TRIPLE:    triple_time_r <= cfg_ch.data;
        CFG_DEBOUNCE:  debounce_r    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_op_r    <= op_t'(in_ch.op);
      in_now_r   <= in_ch.now_ms;
      in_level_r <= in_ch.button_level;
      in_mode_r  <= in_ch.new_mode;
    end
  end

  // Wrapping elapsed times for both machines.
  assign led_elapsed    = in_now_r - led_mark_r;
  assign button_elapsed = in_now_r - button_mark_r;
  assign count_inc      = blink_count_r + 2'd1;

  // Next state of the LED machine and the button machine.
  always_comb begin
    led_mode_nxt     = led_mode_r;
    phase_nxt        = phase_r;
    led_mark_nxt     = led_mark_r;
    button_mark_nxt  = button_mark_r;
    blink_phase_nxt  = blink_phase_r;
    triple_phase_nxt = triple_phase_r;
    blink_count_nxt  = blink_count_r;
    led_pin_nxt      = led_pin_r;
    event_nxt        = 1'b0;

    if (in_op_r == OP_SET) begin
      led_mode_nxt = led_mode_t'(in_mode_r);
    end else begin
      // LED machine runs first.
      case (led_mode_r)
        MODE_DARK: led_pin_nxt = 1'b0;
        MODE_LIT:  led_pin_nxt = 1'b1;
        MODE_BLINK: begin
          if (!blink_phase_r && led_elapsed > TIME_W'(blink_off_r)) begin
            led_pin_nxt     = 1'b1;
            led_mark_nxt    = in_now_r;
            blink_phase_nxt = 1'b1;
          end else if (blink_phase_r && led_elapsed > TIME_W'(blink_on_r)) begin
            led_pin_nxt     = 1'b0;
            led_mark_nxt    = in_now_r;
            blink_phase_nxt = 1'b0;
          end
        end
        default: begin
          if (led_elapsed > TIME_W'(triple_time_r)) begin
            led_mark_nxt     = in_now_r;
            led_pin_nxt      = !triple_phase_r;
            triple_phase_nxt = !triple_phase_r;
            // The third lit-to-dark edge ends the pattern and goes dark.
            if (triple_phase_r) begin
              if (count_inc >= TRIPLE_COUNT) begin
                led_mode_nxt    = MODE_DARK;
                blink_count_nxt = 2'd0;
              end else begin
                blink_count_nxt = count_inc;
              end
            end
          end
        end
      endcase

      // Button machine; a release while debouncing keeps it debouncing.
      case (phase_r)
        PH_DEBOUNCE: begin
          if (button_elapsed > TIME_W'(debounce_r) && !in_level_r) begin
            event_nxt = 1'b1;
            phase_nxt = PH_PRESSED;
          end
        end
        PH_PRESSED: begin
          if (in_level_r) phase_nxt = PH_IDLE;
        end
        default: begin
          if (!in_level_r) begin
            phase_nxt       = PH_DEBOUNCE;
            button_mark_nxt = in_now_r;
          end
        end
      endcase
    end
  end

  // State registers, updated once per word that moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_mode_r     <= MODE_BLINK;
      phase_r        <= PH_IDLE;
      led_mark_r     <= '0;
      button_mark_r  <= '0;
      blink_phase_r  <= 1'b0;
      triple_phase_r <= 1'b0;
      blink_count_r  <= 2'd0;
      led_pin_r      <= 1'b0;
    end else if (advance) begin
      led_mode_r     <= led_mode_nxt;
      phase_r        <= phase_nxt;
      led_mark_r     <= led_mark_nxt;
      button_mark_r  <= button_mark_nxt;
      blink_phase_r  <= blink_phase_nxt;
      triple_phase_r <= triple_phase_nxt;
      blink_count_r  <= blink_count_nxt;
      led_pin_r      <= led_pin_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= advance || (out_vld_r && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_led_r   <= led_pin_nxt;
      out_event_r <= event_nxt;
      out_mode_r  <= led_mode_nxt;
      out_phase_r <= phase_nxt;
    end
  end

  assign out_ch.valid            = out_vld_r;
  assign out_ch.led_level        = out_led_r;
  assign out_ch.press_event      = out_event_r;
  assign out_ch.led_mode_now     = out_mode_r;
  assign out_ch.button_phase_now = out_phase_r;

  // A reported press always leaves the button machine in the pressed phase.
  a_press_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_event_r |-> out_phase_r == PH_PRESSED)
    else $error("press reported outside pressed phase");

  // A set word shows its new mode in the result.
  a_set_mode: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_op_r == OP_SET |=> out_mode_r == led_mode_t'($past(in_mode_r)))
    else $error("set word did not update the mode");

  // The blink counter never reaches the pattern length.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    blink_count_r != TRIPLE_COUNT)
    else $error("blink counter out of range");

  // A held input word is never dropped.
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !advance |=> in_vld_r)
    else $error("input word lost while stalled");

endmodule

// ===== verif/led_pattern_and_button_debounce_tb.sv =====
// ---------------------------------------------------------------------------
// LED pattern and button debounce testbench
// Drives input words, timer register writes and result stalls into the LED
// pattern generator, predicts every result word with an independent model of
// the LED and button machines, and compares each result field by field.
// ---------------------------------------------------------------------------
module led_pattern_and_button_debounce_tb;
  import lpbd_pkg::*;

  // One input word as the channel carries it.
  typedef struct packed {
    op_t         op;
    logic [31:0] now_ms;
    logic        button_level;
    led_mode_t   new_mode;
  } in_word_t;

  // One result word as the channel carries it.
  typedef struct packed {
    logic          led_level;
    logic          press_event;
    led_mode_t     led_mode_now;
    button_phase_t button_phase_now;
  } status_word_t;

  logic clk;
  logic rst_n;

  lpbd_in_if  in_ch();
  lpbd_out_if out_ch();
  lpbd_cfg_if cfg_ch();

  led_pattern_and_button_debounce uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Timer settings as the block should hold them.
  logic [15:0] off_time_ms;
  logic [15:0] on_time_ms;
  logic [15:0] triple_time_ms;
  logic [15:0] debounce_ms;

  // LED and button machine state as the block should hold it.
  led_mode_t     lamp_mode;
  logic          lamp_level;
  logic [31:0]   lamp_mark;
  logic          blink_lit;
  logic          triple_lit;
  logic [1:0]    blinks_done;
  button_phase_t btn_phase;
  logic [31:0]   btn_mark;

  // Status words still owed by the block, oldest first.
  status_word_t pending_status[$];

  // Stimulus state: free-running millisecond clock and the button pin.
  logic [31:0] clock_ms;
  logic        btn_level;
  int          gap_pct;

  int fail_count;
  int words_sent;
  int mode_sets;
  int results_seen;
  int settings_used;
  int presses_seen;
  int triple_runs;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // Build one input word.
  function automatic in_word_t word_of(input op_t op, input logic [31:0] t,
                                       input logic lvl, input led_mode_t m);
    in_word_t w;
    w.op           = op;
    w.now_ms       = t;
    w.button_level = lvl;
    w.new_mode     = m;
    return w;
  endfunction

  // Advance the LED and button machines by one word and return the status.
  function automatic status_word_t predict_status(input in_word_t w);
    status_word_t r;
    logic [31:0]  since_lamp;
    logic [31:0]  since_btn;
    logic         pressed;
    pressed = 1'b0;
    if (w.op == OP_SET) begin
      lamp_mode = w.new_mode;
    end else begin
      // The LED machine runs before the button machine.
      since_lamp = w.now_ms - lamp_mark;
      case (lamp_mode)
        MODE_DARK: lamp_level = 1'b0;
        MODE_LIT:  lamp_level = 1'b1;
        MODE_BLINK: begin
          if (!blink_lit && since_lamp > {16'd0, off_time_ms}) begin
            lamp_level = 1'b1;
            lamp_mark  = w.now_ms;
            blink_lit  = 1'b1;
          end else if (blink_lit && since_lamp > {16'd0, on_time_ms}) begin
            lamp_level = 1'b0;
            lamp_mark  = w.now_ms;
            blink_lit  = 1'b0;
          end
        end
        default: begin
          if (!triple_lit && since_lamp > {16'd0, triple_time_ms}) begin
            lamp_level = 1'b1;
            lamp_mark  = w.now_ms;
            triple_lit = 1'b1;
          end else if (triple_lit && since_lamp > {16'd0, triple_time_ms}) begin
            lamp_level  = 1'b0;
            lamp_mark   = w.now_ms;
            triple_lit  = 1'b0;
            blinks_done = blinks_done + 2'd1;
            // The last blink going dark ends the pattern in dark mode.
            if (blinks_done >= TRIPLE_COUNT) begin
              lamp_mode   = MODE_DARK;
              blinks_done = 2'd0;
              triple_runs++;
            end
          end
        end
      endcase

      // A release while debouncing leaves the machine debouncing.
      since_btn = w.now_ms - btn_mark;
      case (btn_phase)
        PH_DEBOUNCE: begin
          if (since_btn > {16'd0, debounce_ms} && !w.button_level) begin
            pressed   = 1'b1;
            btn_phase = PH_PRESSED;
            presses_seen++;
          end
        end
        PH_PRESSED: begin
          if (w.button_level) btn_phase = PH_IDLE;
        end
        default: begin
          if (!w.button_level) begin
            btn_phase = PH_DEBOUNCE;
            btn_mark  = w.now_ms;
          end
        end
      endcase
    end
    r.led_level        = lamp_level;
    r.press_event      = pressed;
    r.led_mode_now     = lamp_mode;
    r.button_phase_now = btn_phase;
    return r;
  endfunction

  // Send one input word, with an occasional idle burst ahead of it.
  task automatic send_word(input in_word_t w);
    int n;
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      n = $urandom_range(1, 4);
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= w.op;
    in_ch.now_ms       <= w.now_ms;
    in_ch.button_level <= w.button_level;
    in_ch.new_mode     <= w.new_mode;
    do @(posedge clk); while (!in_ch.ready);
    pending_status.push_back(predict_status(w));
    words_sent++;
    if (w.op == OP_SET) mode_sets++;
  endtask

  // Stop sending and wait until every owed status word has come back.
  task automatic finish_traffic();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_status.size() != 0);
  endtask

  // Write all four timer registers once the block is idle.
  task automatic program_timers(input logic [15:0] off_v, input logic [15:0] on_v,
                                input logic [15:0] triple_v, input logic [15:0] deb_v);
    logic [CFG_IDX_W-1:0] idx[4];
    logic [15:0]          val[4];
    idx = '{CFG_BLINK_OFF, CFG_BLINK_ON, CFG_TRIPLE, CFG_DEBOUNCE};
    val = '{off_v, on_v, triple_v, deb_v};
    finish_traffic();
    for (int i = 0; i < 4; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data  <= val[i];
      do @(posedge clk); while (!cfg_ch.ready);
      case (idx[i])
        CFG_BLINK_OFF: off_time_ms    = val[i];
        CFG_BLINK_ON:  on_time_ms     = val[i];
        CFG_TRIPLE:    triple_time_ms = val[i];
        CFG_DEBOUNCE:  debounce_ms    = val[i];
        default: ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // Random traffic: mostly a steadily advancing clock with a bouncing button,
  // plus mode changes, clock jumps and stretches just short of the wrap.
  task automatic run_traffic(input int count);
    in_word_t w;
    int       scale;
    scale = int'(off_time_ms);
    if (on_time_ms > scale) scale = int'(on_time_ms);
    if (triple_time_ms > scale) scale = int'(triple_time_ms);
    if (debounce_ms > scale) scale = int'(debounce_ms);
    scale = scale + 1;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        w = word_of(OP_SET, $urandom(), 1'($urandom_range(0, 1)),
                    led_mode_t'($urandom_range(0, 3)));
      end else begin
        case ($urandom_range(0, 49))
          0:       clock_ms = $urandom();
          1:       clock_ms = 32'hFFFF_FFFF - $urandom_range(0, scale);
          default: clock_ms = clock_ms + $urandom_range(0, scale / 3 + 3);
        endcase
        if ($urandom_range(0, 3) == 0) btn_level = ~btn_level;
        w = word_of(OP_STEP, clock_ms, btn_level, led_mode_t'($urandom_range(0, 3)));
      end
      send_word(w);
    end
  endtask

  // Directed words at reset timers: blink edges, debounce with a release
  // in the middle, every mode, a full three-blink run and the clock wrap.
  task automatic test_directed_cases();
    // A step word ignores its mode field.
    send_word(word_of(OP_STEP, 32'd0, 1'b1, MODE_TRIPLE));
    send_word(word_of(OP_STEP, 32'd901, 1'b1, MODE_DARK));
    send_word(word_of(OP_STEP, 32'd1001, 1'b1, MODE_DARK));
    send_word(word_of(OP_STEP, 32'd1002, 1'b1, MODE_DARK));
    // Press, release while debouncing, then low again after the time.
    send_word(word_of(OP_STEP, 32'd1010, 1'b0, MODE_DARK));
    send_word(word_of(OP_STEP, 32'd1020, 1'b1, MODE_DARK));
    send_word(word_of(OP_STEP, 32'd1061, 1'b1, MODE_DARK));
    send_word(word_of(OP_STEP, 32'd1062, 1'b0, MODE_DARK));
    send_word(word_of(OP_STEP, 32'd1063, 1'b0, MODE_DARK));
    send_word(word_of(OP_STEP, 32'd1064, 1'b1, MODE_DARK));
    // A set word ignores its time and button fields.
    send_word(word_of(OP_SET, 32'hFFFF_FFFF, 1'b0, MODE_LIT));
    send_word(word_of(OP_STEP, 32'd1100, 1'b1, MODE_BLINK));
    send_word(word_of(OP_SET, 32'd0, 1'b1, MODE_DARK));
    send_word(word_of(OP_STEP, 32'd1150, 1'b1, MODE_LIT));
    // Three blinks, ending in dark mode.
    send_word(word_of(OP_SET, 32'd0, 1'b1, MODE_TRIPLE));
    send_word(word_of(OP_STEP, 32'd1203, 1'b1, MODE_DARK));
    send_word(word_of(OP_STEP, 32'd1404, 1'b1, MODE_DARK));
    send_word(word_of(OP_STEP, 32'd1605, 1'b1, MODE_DARK));
    send_word(word_of(OP_STEP, 32'd1806, 1'b1, MODE_DARK));
    send_word(word_of(OP_STEP, 32'd2007, 1'b1, MODE_DARK));
    send_word(word_of(OP_STEP, 32'd2208, 1'b1, MODE_DARK));
    // Blink across the 32-bit wrap of the clock.
    send_word(word_of(OP_SET, 32'd0, 1'b1, MODE_BLINK));
    send_word(word_of(OP_STEP, 32'hFFFF_FFFF, 1'b1, MODE_DARK));
    send_word(word_of(OP_STEP, 32'd100, 1'b1, MODE_DARK));
    clock_ms  = 32'd100;
    btn_level = 1'b1;
  endtask

  // All timers at zero, all at full scale, and a mix of near-extremes.
  task automatic test_timer_extremes();
    gap_pct = 20;
    program_timers(16'd0, 16'd0, 16'd0, 16'd0);
    run_traffic(60);
    program_timers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    clock_ms = $urandom();
    run_traffic(60);
    program_timers(16'd0, 16'hFFFF, 16'd1, 16'hFFFE);
    run_traffic(40);
  endtask

  // Several random timer settings with varying idle pressure; each new
  // setting waits for the block to go fully idle first.
  task automatic test_random_settings();
    int pct_by_phase[5] = '{0, 15, 30, 50, 10};
    for (int p = 0; p < 5; p++) begin
      gap_pct = pct_by_phase[p];
      program_timers(16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)),
                     16'($urandom_range(0, 300)), 16'($urandom_range(0, 120)));
      clock_ms = $urandom();
      run_traffic(130);
    end
  endtask

  // Back-to-back traffic at reset timers with no idling on either side.
  task automatic test_steady_tail();
    program_timers(RST_BLINK_OFF, RST_BLINK_ON, RST_TRIPLE, RST_DEBOUNCE);
    gap_pct = 0;
    run_traffic(100);
  endtask

  // Result side: ready drops in random bursts while idling is enabled.
  initial begin
    int n;
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
        n = $urandom_range(1, 4);
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Compare every accepted result word with the oldest owed status.
  always @(posedge clk) begin
    status_word_t exp;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_status.size() == 0) begin
        $error("result word arrived with no status owed");
        fail_count++;
      end else begin
        exp = pending_status.pop_front();
        if (out_ch.led_level !== exp.led_level) begin
          $error("led_level: expected %0d, got %0d", exp.led_level, out_ch.led_level);
          fail_count++;
        end
        if (out_ch.press_event !== exp.press_event) begin
          $error("press_event: expected %0d, got %0d", exp.press_event,
                 out_ch.press_event);
          fail_count++;
        end
        if (out_ch.led_mode_now !== exp.led_mode_now) begin
          $error("led_mode_now: expected %0d, got %0d", exp.led_mode_now,
                 out_ch.led_mode_now);
          fail_count++;
        end
        if (out_ch.button_phase_now !== exp.button_phase_now) begin
          $error("button_phase_now: expected %0d, got %0d", exp.button_phase_now,
                 out_ch.button_phase_now);
          fail_count++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.op           <= OP_STEP;
    in_ch.now_ms       <= '0;
    in_ch.button_level <= 1'b1;
    in_ch.new_mode     <= MODE_DARK;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= CFG_BLINK_OFF;
    cfg_ch.data        <= '0;

    // Model state right after reset.
    off_time_ms    = RST_BLINK_OFF;
    on_time_ms     = RST_BLINK_ON;
    triple_time_ms = RST_TRIPLE;
    debounce_ms    = RST_DEBOUNCE;
    lamp_mode      = MODE_BLINK;
    lamp_level     = 1'b0;
    lamp_mark      = '0;
    blink_lit      = 1'b0;
    triple_lit     = 1'b0;
    blinks_done    = 2'd0;
    btn_phase      = PH_IDLE;
    btn_mark       = '0;
    clock_ms       = '0;
    btn_level      = 1'b1;
    gap_pct        = 0;
    fail_count     = 0;
    words_sent     = 0;
    mode_sets      = 0;
    results_seen   = 0;
    settings_used  = 1;
    presses_seen   = 0;
    triple_runs    = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_timer_extremes();
    test_random_settings();
    test_steady_tail();

    finish_traffic();
    repeat (10) @(posedge clk);

    $display("Sent %0d input words (%0d mode changes), checked %0d results, %0d timer sets.",
             words_sent, mode_sets, results_seen, settings_used);
    $display("Saw %0d debounced presses and %0d completed three-blink patterns.",
             presses_seen, triple_runs);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
